// File: src/positional_list_insert_delete_assert.svh
// Assertion macros for the positional list block.
// Used by positional_list_insert_delete; needs i_clk and i_rst_n in scope.
`ifndef POSITIONAL_LIST_INSERT_DELETE_ASSERT_SVH
`define POSITIONAL_LIST_INSERT_DELETE_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define PL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define PL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/pos_list_pkg.sv
// Shared types and status codes for the positional list block.
// No dependencies; used by the top level and the testbench.
package pos_list_pkg;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    // Request kinds
    localparam logic KIND_DELETE = 1'b0;
    localparam logic KIND_INSERT = 1'b1;

    // One result beat
    typedef struct packed {
        logic [1:0]         status;
        logic               has_element;
        logic [2:0]         element_index;
        logic signed [31:0] element_value;
        logic [3:0]         list_count;
        logic               last;
    } t_out_beat;

endpackage

// File: src/pos_list_in_if.sv
// Request channel of the positional list block: valid/ready plus request fields.
// Depends on nothing.
interface pos_list_in_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [3:0]         position;
    logic signed [31:0] new_value;

    modport source (output valid, output kind, output position, output new_value,
                     input ready);
    modport sink   (input valid, input kind, input position, input new_value,
                     output ready);
endinterface

// File: src/pos_list_out_if.sv
// Result channel of the positional list block: valid/ready plus result fields.
// Depends on nothing.
interface pos_list_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic               has_element;
    logic [2:0]         element_index;
    logic signed [31:0] element_value;
    logic [3:0]         list_count;
    logic               last;

    modport source (output valid, output status, output has_element,
                     output element_index, output element_value, output list_count,
                     output last, input ready);
    modport sink   (input valid, input status, input has_element,
                     input element_index, input element_value, input list_count,
                     input last, output ready);
endinterface

// File: src/positional_list_insert_delete.sv
// A rejected request gives its one result beat from S_REPORT after acceptance.
// A good request shifts the entries it moves (then writes the new value for an
// insert), then streams the list at one beat per cycle while o_out is not stalled.
// One memory port pair does both the shift and the readout, which sets the rate.
// Reset (synchronous, active low) empties the list; stored values are not cleared.
`include "positional_list_insert_delete_assert.svh"

module positional_list_insert_delete #(
    parameter int CAPACITY = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    pos_list_in_if.sink    i_in,
    pos_list_out_if.source o_out
);

    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > 4) ? CW : 4;

    // Sequencer states
    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_SHIFT     = 3'd1;
    localparam logic [2:0] S_WRITE_NEW = 3'd2;
    localparam logic [2:0] S_DUMP      = 3'd3;
    localparam logic [2:0] S_REPORT    = 3'd4;

    logic [2:0]         r_state, n_state;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic               r_kind, n_kind;
    logic [AW-1:0]      r_pos, n_pos;
    logic signed [31:0] r_val, n_val;
    logic [1:0]         r_status, n_status;
    logic [AW-1:0]      r_ptr, n_ptr;
    logic [CW-1:0]      r_moves, n_moves;
    logic               r_wpend, n_wpend;
    logic [AW-1:0]      r_waddr, n_waddr;
    logic               r_rd_pend, n_rd_pend;
    logic [AW-1:0]      r_pidx, n_pidx;
    logic               r_out_valid, n_out_valid;
    pos_list_pkg::t_out_beat r_out, n_out;

    // List storage, one write and one registered read per cycle
    logic signed [31:0] r_mem [CAPACITY];
    logic signed [31:0] r_rd_data;
    logic               mem_we, mem_re;
    logic [AW-1:0]      mem_waddr, mem_raddr;
    logic signed [31:0] mem_wdata;

    logic [CMPW-1:0] pos_x, cnt_x;
    logic            out_free, dump_take;

    assign pos_x    = CMPW'(i_in.position);
    assign cnt_x    = CMPW'(r_cnt);
    assign out_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    // Sequencer: accept, shift, write, stream out
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_kind      = r_kind;
        n_pos       = r_pos;
        n_val       = r_val;
        n_status    = r_status;
        n_ptr       = r_ptr;
        n_moves     = r_moves;
        n_wpend     = r_wpend;
        n_waddr     = r_waddr;
        n_rd_pend   = r_rd_pend;
        n_pidx      = r_pidx;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = r_waddr;
        mem_wdata   = r_rd_data;
        mem_raddr   = r_ptr;
        dump_take   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_kind   = i_in.kind;
                    n_pos    = AW'(i_in.position);
                    n_val    = i_in.new_value;
                    n_status = pos_list_pkg::ST_OK;
                    n_wpend  = 1'b0;
                    if (i_in.kind == pos_list_pkg::KIND_INSERT) begin
                        if (cnt_x >= CMPW'(CAPACITY)) begin
                            n_status = pos_list_pkg::ST_FULL;
                            n_state  = S_REPORT;
                        end else if (pos_x > cnt_x) begin
                            n_status = pos_list_pkg::ST_RANGE;
                            n_state  = S_REPORT;
                        end else begin
                            n_cnt   = r_cnt + CW'(1);
                            n_moves = CW'(cnt_x - pos_x);
                            n_ptr   = AW'(cnt_x - CMPW'(1));
                            n_state = S_SHIFT;
                        end
                    end else begin
                        if (r_cnt == '0) begin
                            n_status = pos_list_pkg::ST_EMPTY;
                            n_state  = S_REPORT;
                        end else if (pos_x >= cnt_x) begin
                            n_status = pos_list_pkg::ST_RANGE;
                            n_state  = S_REPORT;
                        end else begin
                            n_cnt   = r_cnt - CW'(1);
                            n_moves = CW'(cnt_x - CMPW'(1) - pos_x);
                            n_ptr   = AW'(pos_x + CMPW'(1));
                            n_state = S_SHIFT;
                        end
                    end
                end
            end

            // Move entries one slot; the read of one overlaps the write of the last
            S_SHIFT: begin
                if (r_wpend) begin
                    mem_we = 1'b1;
                end
                if (r_moves != '0) begin
                    mem_re  = 1'b1;
                    n_wpend = 1'b1;
                    n_moves = r_moves - CW'(1);
                    if (r_kind == pos_list_pkg::KIND_INSERT) begin
                        n_waddr = r_ptr + AW'(1);
                        n_ptr   = r_ptr - AW'(1);
                    end else begin
                        n_waddr = r_ptr - AW'(1);
                        n_ptr   = r_ptr + AW'(1);
                    end
                end else begin
                    n_wpend = 1'b0;
                    if (r_kind == pos_list_pkg::KIND_INSERT) begin
                        n_state = S_WRITE_NEW;
                    end else if (r_cnt == '0) begin
                        n_state = S_REPORT;
                    end else begin
                        n_state   = S_DUMP;
                        n_ptr     = '0;
                        n_moves   = r_cnt;
                        n_rd_pend = 1'b0;
                    end
                end
            end

            S_WRITE_NEW: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos;
                mem_wdata = r_val;
                n_state   = S_DUMP;
                n_ptr     = '0;
                n_moves   = r_cnt;
                n_rd_pend = 1'b0;
            end

            // Stream entries; a new read issues as the pending word moves out
            S_DUMP: begin
                dump_take = r_rd_pend && out_free;
                if (dump_take) begin
                    n_out_valid         = 1'b1;
                    n_out.status        = pos_list_pkg::ST_OK;
                    n_out.has_element   = 1'b1;
                    n_out.element_index = 3'(r_pidx);
                    n_out.element_value = r_rd_data;
                    n_out.list_count    = 4'(r_cnt);
                    n_out.last          = ((CW'(r_pidx) + CW'(1)) == r_cnt);
                end
                if (!r_rd_pend || dump_take) begin
                    if (r_moves != '0) begin
                        mem_re    = 1'b1;
                        n_pidx    = r_ptr;
                        n_ptr     = r_ptr + AW'(1);
                        n_moves   = r_moves - CW'(1);
                        n_rd_pend = 1'b1;
                    end else begin
                        n_rd_pend = 1'b0;
                        n_state   = S_IDLE;
                    end
                end
            end

            // Single beat: error, or the list is now empty
            S_REPORT: begin
                if (out_free) begin
                    n_out_valid         = 1'b1;
                    n_out.status        = r_status;
                    n_out.has_element   = 1'b0;
                    n_out.element_index = '0;
                    n_out.element_value = '0;
                    n_out.list_count    = 4'(r_cnt);
                    n_out.last          = 1'b1;
                    n_state             = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_wpend     <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_wpend     <= n_wpend;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload and pointers
    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_status <= n_status;
        r_ptr    <= n_ptr;
        r_moves  <= n_moves;
        r_waddr  <= n_waddr;
        r_pidx   <= n_pidx;
        r_out    <= n_out;
    end

    // Channel ports
    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_out.status;
    assign o_out.has_element   = r_out.has_element;
    assign o_out.element_index = r_out.element_index;
    assign o_out.element_value = r_out.element_value;
    assign o_out.list_count    = r_out.list_count;
    assign o_out.last          = r_out.last;

    // Checks
    `PL_ASSERT_IMP(a_cnt_bound, 1'b1, CMPW'(r_cnt) <= CMPW'(CAPACITY), "fill count overflow")
    `PL_ASSERT_IMP(a_idle_no_write, r_state == S_IDLE, !mem_we, "memory write while idle")
    `PL_ASSERT_IMP(a_elem_ok, r_out_valid && r_out.has_element, r_out.status == pos_list_pkg::ST_OK, "element beat with error status")
    `PL_ASSERT_IMP(a_pidx_bound, r_state == S_DUMP && r_rd_pend, CW'(r_pidx) < r_cnt, "readout past fill count")
    `PL_ASSERT_NEXT(a_take_holds, r_out_valid && !o_out.ready, r_out_valid, "result beat dropped under stall")

endmodule

// File: tb/testbench.sv
// Self-checking testbench for positional_list_insert_delete: drives insert and
// delete requests, predicts every result beat and checks each one as it arrives.
// Depends on pos_list_pkg, pos_list_in_if, pos_list_out_if and the top level.
`timescale 1ns / 1ps

module testbench;

    localparam int CAPACITY    = 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 8;

    logic i_clk;
    logic i_rst_n;

    pos_list_in_if  req_ch();
    pos_list_out_if rsp_ch();

    positional_list_insert_delete #(.CAPACITY(CAPACITY)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (rsp_ch)
    );

    // Predicted list contents and fill count
    logic signed [31:0]       list_model [CAPACITY];
    int                       list_fill;
    pos_list_pkg::t_out_beat  expected_beats [$];

    int  mismatches = 0;
    int  cycle_count = 0;
    bit  steady;       // when set, neither side inserts idle cycles

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Apply one accepted request to the list copy and queue the beats it causes
    function automatic void predict_list_update(logic kind, logic [3:0] pos,
                                                logic signed [31:0] val);
        pos_list_pkg::t_out_beat beat;
        int                      i;
        beat            = '0;
        beat.last       = 1'b1;
        beat.list_count = list_fill[3:0];
        if (kind == pos_list_pkg::KIND_INSERT) begin
            if (list_fill >= CAPACITY) begin
                beat.status = pos_list_pkg::ST_FULL;
                expected_beats.push_back(beat);
                return;
            end
            if (int'(pos) > list_fill) begin
                beat.status = pos_list_pkg::ST_RANGE;
                expected_beats.push_back(beat);
                return;
            end
            for (i = list_fill; i > int'(pos); i--)
                list_model[i] = list_model[i-1];
            list_model[pos] = val;
            list_fill++;
        end else begin
            if (list_fill == 0) begin
                beat.status = pos_list_pkg::ST_EMPTY;
                expected_beats.push_back(beat);
                return;
            end
            if (int'(pos) >= list_fill) begin
                beat.status = pos_list_pkg::ST_RANGE;
                expected_beats.push_back(beat);
                return;
            end
            for (i = pos; i + 1 < list_fill; i++)
                list_model[i] = list_model[i+1];
            list_fill--;
        end

        // Emptied list: one beat, no element
        if (list_fill == 0) begin
            beat            = '0;
            beat.status     = pos_list_pkg::ST_OK;
            beat.last       = 1'b1;
            expected_beats.push_back(beat);
            return;
        end
        for (i = 0; i < list_fill; i++) begin
            beat.status        = pos_list_pkg::ST_OK;
            beat.has_element   = 1'b1;
            beat.element_index = i[2:0];
            beat.element_value = list_model[i];
            beat.list_count    = list_fill[3:0];
            beat.last          = (i == list_fill - 1);
            expected_beats.push_back(beat);
        end
    endfunction

    function automatic void check_field(string field, logic [31:0] want,
                                        logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, want, got);
            mismatches++;
        end
    endfunction

    // Result checker: every accepted beat against the oldest prediction
    always @(posedge i_clk) begin
        pos_list_pkg::t_out_beat want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual status %0d",
                         $time, rsp_ch.status);
                mismatches++;
            end else begin
                want = expected_beats.pop_front();
                check_field("status", 32'(want.status), 32'(rsp_ch.status));
                check_field("has_element", 32'(want.has_element),
                            32'(rsp_ch.has_element));
                check_field("element_index", 32'(want.element_index),
                            32'(rsp_ch.element_index));
                check_field("element_value", want.element_value, rsp_ch.element_value);
                check_field("list_count", 32'(want.list_count), 32'(rsp_ch.list_count));
                check_field("last", 32'(want.last), 32'(rsp_ch.last));
            end
        end
    end

    // Result sink: random stall before each beat
    initial begin
        int stall;
        rsp_ch.ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 18);
            if (stall > 0) begin
                rsp_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            rsp_ch.ready = 1'b1;
            @(posedge i_clk);
            while (!rsp_ch.valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    // Send one request beat; called and returns at a falling edge.
    // valid stays high on return so back-to-back beats need no toggle.
    task automatic send_request(input logic kind, input logic [3:0] pos,
                                input logic signed [31:0] val);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.kind      = kind;
        req_ch.position  = pos;
        req_ch.new_value = val;
        req_ch.valid     = 1'b1;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        predict_list_update(kind, pos, val);
        @(negedge i_clk);
    endtask

    // Hold off the sender until every predicted beat has arrived
    task automatic wait_results_drained();
        req_ch.valid = 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // Extremes, each error code, empty and full list
    task automatic test_boundaries();
        send_request(pos_list_pkg::KIND_DELETE, 4'd0, 32'sd0);     // delete from empty
        send_request(pos_list_pkg::KIND_DELETE, 4'd15, -32'sd1);   // empty, top position
        send_request(pos_list_pkg::KIND_INSERT, 4'd1, 32'sd5);     // insert past end
        send_request(pos_list_pkg::KIND_INSERT, 4'd15, 32'sd5);
        send_request(pos_list_pkg::KIND_INSERT, 4'd0, 32'h7fffffff);
        send_request(pos_list_pkg::KIND_DELETE, 4'd0, 32'sd0);     // list back to empty
        send_request(pos_list_pkg::KIND_INSERT, 4'd0, 32'h80000000);
        send_request(pos_list_pkg::KIND_INSERT, 4'd1, -32'sd1);    // append
        send_request(pos_list_pkg::KIND_INSERT, 4'd0, 32'sd0);     // front
        send_request(pos_list_pkg::KIND_INSERT, 4'd1, 32'sd1);     // middle
        send_request(pos_list_pkg::KIND_INSERT, 4'd4, 32'haaaaaaaa);
        send_request(pos_list_pkg::KIND_INSERT, 4'd2, 32'h55555555);
        send_request(pos_list_pkg::KIND_INSERT, 4'd6, 32'h7fffffff);
        send_request(pos_list_pkg::KIND_INSERT, 4'd7, 32'h80000000); // now full
        send_request(pos_list_pkg::KIND_INSERT, 4'd0, 32'sd3);     // insert into full
        send_request(pos_list_pkg::KIND_INSERT, 4'd15, 32'sd3);
        send_request(pos_list_pkg::KIND_DELETE, 4'd8, 32'sd0);     // delete past end
        send_request(pos_list_pkg::KIND_DELETE, 4'd15, 32'sd0);
        send_request(pos_list_pkg::KIND_DELETE, 4'd7, 32'sd0);     // last entry
        send_request(pos_list_pkg::KIND_INSERT, 4'd8, 32'sd9);     // past the append position
        send_request(pos_list_pkg::KIND_DELETE, 4'd0, 32'sd0);
        send_request(pos_list_pkg::KIND_DELETE, 4'd3, 32'sd0);
    endtask

    // Random requests; grow_pct sets how often a list neither empty nor full gets an insert
    task automatic run_random_requests(int count, int grow_pct);
        logic               kind;
        logic [3:0]         pos;
        logic signed [31:0] val;
        int                 n;
        for (n = 0; n < count; n++) begin
            if (list_fill == 0)
                kind = ($urandom_range(0, 9) != 0) ? pos_list_pkg::KIND_INSERT
                                                   : pos_list_pkg::KIND_DELETE;
            else if (list_fill >= CAPACITY)
                kind = ($urandom_range(0, 5) != 0) ? pos_list_pkg::KIND_DELETE
                                                   : pos_list_pkg::KIND_INSERT;
            else
                kind = ($urandom_range(0, 99) < grow_pct) ? pos_list_pkg::KIND_INSERT
                                                          : pos_list_pkg::KIND_DELETE;

            // mostly legal positions, some anywhere in the field
            if ($urandom_range(0, 9) == 0)
                pos = 4'($urandom_range(0, 15));
            else if (kind == pos_list_pkg::KIND_INSERT)
                pos = 4'($urandom_range(0, list_fill));
            else
                pos = (list_fill > 0) ? 4'($urandom_range(0, list_fill - 1)) : 4'd0;

            case ($urandom_range(0, 7))
                0:       val = 32'h7fffffff;
                1:       val = 32'h80000000;
                2:       val = 32'sd0;
                default: val = $urandom;
            endcase
            send_request(kind, pos, val);
        end
    endtask

    task automatic test_growth();
        run_random_requests(30, 80);
    endtask

    task automatic test_shrink();
        run_random_requests(30, 25);
    endtask

    task automatic test_back_to_back();
        steady = 1'b1;
        run_random_requests(15, 55);
        steady = 1'b0;
        run_random_requests(15, 50);
    endtask

    // Sequence of tests
    initial begin
        int i;
        steady           = 1'b0;
        list_fill        = 0;
        for (i = 0; i < CAPACITY; i++)
            list_model[i] = '0;
        i_rst_n          = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.kind      = pos_list_pkg::KIND_DELETE;
        req_ch.position  = '0;
        req_ch.new_value = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_boundaries();
        wait_results_drained();
        test_growth();
        wait_results_drained();
        test_shrink();
        test_back_to_back();
        wait_results_drained();

        if (mismatches == 0 && expected_beats.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/pos_list_pkg.sv
src/pos_list_in_if.sv
src/pos_list_out_if.sv
src/positional_list_insert_delete.sv
tb/testbench.sv
